// File: hdl/grid_maze_backtracker_unit_macros.svh
`ifndef GRID_MAZE_BACKTRACKER_UNIT_MACROS_SVH
`define GRID_MAZE_BACKTRACKER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define GMB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define GMB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/gmb_pkg.sv
package gmb_pkg;

  // default grid limits
  localparam int unsigned MaxRowsDef = 32;
  localparam int unsigned MaxColsDef = 32;

  // field widths
  localparam int unsigned CoordW   = 6;
  localparam int unsigned PosW     = 5;
  localparam int unsigned WallW    = 4;
  localparam int unsigned RandW    = 32;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 6;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [WallW-1:0]  walls_t;

  // wall bits of a cell
  localparam walls_t WallLeft   = 4'b0001;
  localparam walls_t WallTop    = 4'b0010;
  localparam walls_t WallRight  = 4'b0100;
  localparam walls_t WallBottom = 4'b1000;
  localparam walls_t WallAll    = 4'b1111;

  typedef enum logic [ModeW-1:0] {
    MODE_STEP     = 2'd0,
    MODE_READ     = 2'd1,
    MODE_CLEAR    = 2'd2,
    MODE_READ_ALT = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_ROWS = 3'd0,
    CFG_GRID_COLS = 3'd1,
    CFG_START_ROW = 3'd2,
    CFG_START_COL = 3'd3,
    CFG_ENTRY_ROW = 3'd4,
    CFG_EXIT_ROW  = 3'd5
  } cfg_idx_e;

  // walk directions in candidate order
  typedef enum logic [1:0] {
    DIR_DOWN  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_e;

  typedef struct packed {
    logic   visited;
    walls_t walls;
  } cell_t;

  typedef struct packed {
    coord_t row;
    coord_t col;
  } pos_t;

  // wall opened in the arriving cell, toward the cell left behind
  function automatic walls_t back_wall(input dir_e d);
    walls_t w;
    case (d)
      DIR_DOWN:  w = WallBottom;
      DIR_RIGHT: w = WallLeft;
      DIR_UP:    w = WallTop;
      DIR_LEFT:  w = WallRight;
      default:   w = WallBottom;
    endcase
    return w;
  endfunction

  // wall opened in the departing cell
  function automatic walls_t move_wall(input dir_e d);
    walls_t w;
    case (d)
      DIR_DOWN:  w = WallTop;
      DIR_RIGHT: w = WallRight;
      DIR_UP:    w = WallBottom;
      DIR_LEFT:  w = WallLeft;
      default:   w = WallTop;
    endcase
    return w;
  endfunction

  function automatic coord_t clamp_coord(input coord_t v, input coord_t n);
    return (v < n) ? v : coord_t'(n - coord_t'(1));
  endfunction

  function automatic logic nbr_exists(input dir_e d, input pos_t p,
                                      input coord_t rows, input coord_t cols);
    logic ok;
    case (d)
      DIR_DOWN:  ok = (p.row + coord_t'(1)) < rows;
      DIR_RIGHT: ok = (p.col + coord_t'(1)) < cols;
      DIR_UP:    ok = (p.row != '0);
      DIR_LEFT:  ok = (p.col != '0);
      default:   ok = 1'b0;
    endcase
    return ok;
  endfunction

  // neighbor position, or the position itself at the grid edge
  function automatic pos_t step_pos(input dir_e d, input pos_t p,
                                    input coord_t rows, input coord_t cols);
    pos_t q;
    q = p;
    if (nbr_exists(d, p, rows, cols)) begin
      case (d)
        DIR_DOWN:  q.row = p.row + coord_t'(1);
        DIR_RIGHT: q.col = p.col + coord_t'(1);
        DIR_UP:    q.row = p.row - coord_t'(1);
        DIR_LEFT:  q.col = p.col - coord_t'(1);
        default:   q = p;
      endcase
    end
    return q;
  endfunction

  // sum of eight base-4 digits, feeds the mod-3 reduction
  function automatic logic [4:0] digit_sum8(input logic [15:0] v);
    logic [4:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    return s;
  endfunction

  // value mod 3 of a digit sum, since 4 is 1 mod 3
  function automatic logic [1:0] mod3_of_sum(input logic [5:0] s);
    logic [3:0] t;
    logic [1:0] r;
    t = 4'(s[5:4]) + 4'(s[3:2]) + 4'(s[1:0]);
    case (t)
      4'd0, 4'd3, 4'd6, 4'd9: r = 2'd0;
      4'd1, 4'd4, 4'd7:       r = 2'd1;
      4'd2, 4'd5, 4'd8:       r = 2'd2;
      default:                r = 2'd0;
    endcase
    return r;
  endfunction

  // k-th set candidate, counting from direction zero
  function automatic dir_e pick_dir(input logic [3:0] cand, input logic [1:0] k);
    logic [1:0] cnt;
    logic       found;
    dir_e       d;
    cnt   = '0;
    found = 1'b0;
    d     = DIR_DOWN;
    for (int i = 0; i < 4; i++) begin
      if (cand[i] && !found) begin
        if (cnt == k) begin
          d     = dir_e'(2'(i));
          found = 1'b1;
        end
        cnt = cnt + 2'd1;
      end
    end
    return d;
  endfunction

endpackage

// File: hdl/gmb_if.sv
// request channel
interface gmb_in_if;
  import gmb_pkg::*;
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic [RandW-1:0] rand_value;
  logic [PosW-1:0]  query_row;
  logic [PosW-1:0]  query_col;

  modport source (output valid, mode, rand_value, query_row, query_col, input ready);
  modport sink (input valid, mode, rand_value, query_row, query_col, output ready);
endinterface

// result channel
interface gmb_out_if;
  import gmb_pkg::*;
  logic             valid;
  logic             ready;
  logic [PosW-1:0]  pos_row;
  logic [PosW-1:0]  pos_col;
  logic [WallW-1:0] wall_bits;
  logic             finished;
  logic             advanced;

  modport source (output valid, pos_row, pos_col, wall_bits, finished, advanced,
                  input ready);
  modport sink (input valid, pos_row, pos_col, wall_bits, finished, advanced,
                output ready);
endinterface

// File: hdl/grid_maze_backtracker_unit.sv
// Depth-first maze carver. Requests arrive on in_i (valid/ready), one result
// per request leaves on out_o (valid/ready); a transaction completes when
// valid and ready are both high. Six registers (up to 6 bits) are written by
// the user through cfg_we_i/cfg_idx_i/cfg_data_i while the block is idle; the
// block itself does not enforce this. Visited bits and walls live in one
// MAX_ROWS*MAX_COLS cell memory, the backtrack positions in a stack memory
// of the same depth; both are single-read, single-write with a registered
// read port, so the cell reads of a step are issued one after another.
// A read (modes 1, 3) reads the queried cell, then reports. A walk step reads
// the current cell and the four neighbors in turn, decides, checks, reports;
// it adds a pop state when it takes a stored cell, and on completing the maze
// it writes the entrance, reads and writes the exit, rereads the current cell.
// A finished walk step only reports; clear and restart sweeps the cell memory
// and reports. in_i.ready rises in the cycle after the result is loaded. After
// reset all MAX_ROWS*MAX_COLS cells (1024 at the defaults) are swept before
// in_i.ready rises; configuration writes are taken during the sweep. A stalled
// receiver holds the result in the output register; one more request may be
// accepted, and its result waits in the block until that register is free.
module grid_maze_backtracker_unit #(
  parameter int unsigned MAX_ROWS = gmb_pkg::MaxRowsDef,
  parameter int unsigned MAX_COLS = gmb_pkg::MaxColsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  gmb_in_if.sink                       in_i,
  gmb_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [gmb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gmb_pkg::CfgDataW-1:0] cfg_data_i
);
  import gmb_pkg::*;

  localparam int unsigned Cells = MAX_ROWS * MAX_COLS;
  localparam int unsigned AddrW = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int unsigned CntW  = $clog2(Cells + 1);

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CntW-1:0]  cnt_t;

  typedef enum logic [11:0] {
    S_CLEAR   = 12'b0000_0000_0001,
    S_IDLE    = 12'b0000_0000_0010,
    S_HERE    = 12'b0000_0000_0100,
    S_NBR     = 12'b0000_0000_1000,
    S_DECIDE  = 12'b0000_0001_0000,
    S_POP     = 12'b0000_0010_0000,
    S_FINCHK  = 12'b0000_0100_0000,
    S_ENT_WR  = 12'b0000_1000_0000,
    S_EXIT_RD = 12'b0001_0000_0000,
    S_EXIT_WR = 12'b0010_0000_0000,
    S_REP_RD  = 12'b0100_0000_0000,
    S_REPORT  = 12'b1000_0000_0000
  } state_e;

  function automatic addr_t cell_addr(input pos_t p);
    return AddrW'(32'(p.row) * MAX_COLS + 32'(p.col));
  endfunction

  // configuration registers
  coord_t          rows_cfg_q, rows_cfg_d, cols_cfg_q, cols_cfg_d;
  logic [PosW-1:0] start_row_q, start_row_d, start_col_q, start_col_d;
  logic [PosW-1:0] entry_row_q, entry_row_d, exit_row_q, exit_row_d;

  // walk state
  state_e     state_q, state_d;
  pos_t       walk_q, walk_d;
  cnt_t       seen_q, seen_d;
  cnt_t       depth_q, depth_d;
  logic       first_q, first_d;
  logic       popped_q, popped_d;
  dir_e       last_dir_q, last_dir_d;
  logic       moved_q, moved_d;
  logic [1:0] dir_q, dir_d;
  logic [3:0] cand_q, cand_d;
  addr_t      clr_q, clr_d;
  logic       clr_rep_q, clr_rep_d;

  // per-item data
  walls_t           walls_q, walls_d;
  logic [RandW-1:0] rnd_q, rnd_d;
  logic [4:0]       sum_lo_q, sum_lo_d, sum_hi_q, sum_hi_d;

  // output register
  logic            out_valid_q, out_valid_d;
  logic [PosW-1:0] out_row_q, out_row_d, out_col_q, out_col_d;
  walls_t          out_walls_q, out_walls_d;
  logic            out_fin_q, out_fin_d, out_adv_q, out_adv_d;

  // memory ports
  cell_t cell_mem [Cells];
  logic  cell_re, cell_we;
  addr_t cell_raddr, cell_waddr;
  cell_t cell_wdata, cell_rdata_q;
  pos_t  stack_mem [Cells];
  logic  stack_re, stack_we;
  addr_t stack_raddr, stack_waddr;
  pos_t  stack_wdata, stack_rdata_q;

  // derived values
  coord_t                rows_used, cols_used;
  logic [2*CoordW-1:0]   total;
  logic                  finished;
  pos_t                  start_pos, here_pos, query_pos, entry_pos, exit_pos;
  dir_e                  nbr_dir, pick;
  logic [2:0]            cand_cnt;
  logic [1:0]            pick_idx;
  cnt_t                  depth_m1;
  logic                  in_ready;

  // grid size in use
  always_comb begin
    if (rows_cfg_q == '0) begin
      rows_used = coord_t'(1);
    end else if (32'(rows_cfg_q) > MAX_ROWS) begin
      rows_used = coord_t'(MAX_ROWS);
    end else begin
      rows_used = rows_cfg_q;
    end
    if (cols_cfg_q == '0) begin
      cols_used = coord_t'(1);
    end else if (32'(cols_cfg_q) > MAX_COLS) begin
      cols_used = coord_t'(MAX_COLS);
    end else begin
      cols_used = cols_cfg_q;
    end
  end

  assign total    = {{CoordW{1'b0}}, rows_used} * {{CoordW{1'b0}}, cols_used};
  assign finished = 32'(seen_q) >= 32'(total);

  // clamped positions
  assign start_pos.row = clamp_coord(coord_t'(start_row_q), rows_used);
  assign start_pos.col = clamp_coord(coord_t'(start_col_q), cols_used);
  assign query_pos.row = clamp_coord(coord_t'(in_i.query_row), rows_used);
  assign query_pos.col = clamp_coord(coord_t'(in_i.query_col), cols_used);
  assign entry_pos.row = clamp_coord(coord_t'(entry_row_q), rows_used);
  assign entry_pos.col = '0;
  assign exit_pos.row  = clamp_coord(coord_t'(exit_row_q), rows_used);
  assign exit_pos.col  = cols_used - coord_t'(1);

  always_comb begin
    if (first_q) begin
      here_pos = start_pos;
    end else begin
      here_pos.row = clamp_coord(walk_q.row, rows_used);
      here_pos.col = clamp_coord(walk_q.col, cols_used);
    end
  end

  // neighbor to read next and direction pick
  assign nbr_dir  = (state_q == S_HERE) ? DIR_DOWN : dir_e'(dir_q + 2'd1);
  assign cand_cnt = 3'($countones(cand_q));
  assign depth_m1 = depth_q - cnt_t'(1);

  always_comb begin
    case (cand_cnt)
      3'd2:    pick_idx = {1'b0, rnd_q[0]};
      3'd3:    pick_idx = mod3_of_sum({1'b0, sum_lo_q} + {1'b0, sum_hi_q});
      3'd4:    pick_idx = rnd_q[1:0];
      default: pick_idx = 2'd0;
    endcase
  end

  assign pick = pick_dir(cand_q, pick_idx);

  // configuration writes
  always_comb begin
    rows_cfg_d  = rows_cfg_q;
    cols_cfg_d  = cols_cfg_q;
    start_row_d = start_row_q;
    start_col_d = start_col_q;
    entry_row_d = entry_row_q;
    exit_row_d  = exit_row_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GRID_ROWS: rows_cfg_d  = cfg_data_i;
        CFG_GRID_COLS: cols_cfg_d  = cfg_data_i;
        CFG_START_ROW: start_row_d = cfg_data_i[PosW-1:0];
        CFG_START_COL: start_col_d = cfg_data_i[PosW-1:0];
        CFG_ENTRY_ROW: entry_row_d = cfg_data_i[PosW-1:0];
        CFG_EXIT_ROW:  exit_row_d  = cfg_data_i[PosW-1:0];
        default: ;
      endcase
    end
  end

  // step sequencer
  always_comb begin
    state_d     = state_q;
    walk_d      = walk_q;
    seen_d      = seen_q;
    depth_d     = depth_q;
    first_d     = first_q;
    popped_d    = popped_q;
    last_dir_d  = last_dir_q;
    moved_d     = moved_q;
    dir_d       = dir_q;
    cand_d      = cand_q;
    clr_d       = clr_q;
    clr_rep_d   = clr_rep_q;
    walls_d     = walls_q;
    rnd_d       = rnd_q;
    sum_lo_d    = sum_lo_q;
    sum_hi_d    = sum_hi_q;
    out_valid_d = out_valid_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_walls_d = out_walls_q;
    out_fin_d   = out_fin_q;
    out_adv_d   = out_adv_q;
    cell_re     = 1'b0;
    cell_raddr  = cell_addr(walk_q);
    cell_we     = 1'b0;
    cell_waddr  = cell_addr(walk_q);
    cell_wdata  = cell_rdata_q;
    stack_re    = 1'b0;
    stack_raddr = depth_m1[AddrW-1:0];
    stack_we    = 1'b0;
    stack_waddr = depth_q[AddrW-1:0];
    stack_wdata = walk_q;
    in_ready    = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      // sweep every cell back to unvisited and closed
      S_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_q;
        cell_wdata = '{visited: 1'b0, walls: WallAll};
        if (clr_q == AddrW'(Cells - 1)) begin
          clr_d     = '0;
          clr_rep_d = 1'b0;
          state_d   = clr_rep_q ? S_REP_RD : S_IDLE;
        end else begin
          clr_d = clr_q + addr_t'(1);
        end
      end

      // take a request and issue its first read, or start the sweep for a clear
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          rnd_d   = in_i.rand_value;
          moved_d = 1'b0;
          case (mode_e'(in_i.mode))
            MODE_STEP: begin
              cell_re = 1'b1;
              if (finished) begin
                cell_raddr = cell_addr(walk_q);
                state_d    = S_REPORT;
              end else begin
                walk_d     = here_pos;
                cell_raddr = cell_addr(here_pos);
                state_d    = S_HERE;
              end
            end
            MODE_READ, MODE_READ_ALT: begin
              cell_re    = 1'b1;
              cell_raddr = cell_addr(query_pos);
              state_d    = S_REPORT;
            end
            MODE_CLEAR: begin
              walk_d     = start_pos;
              seen_d     = '0;
              depth_d    = '0;
              first_d    = 1'b1;
              popped_d   = 1'b0;
              last_dir_d = DIR_DOWN;
              clr_d      = '0;
              clr_rep_d  = 1'b1;
              state_d    = S_CLEAR;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      // current cell arrived: count it if unvisited, open the back wall after a move, start neighbor reads
      S_HERE: begin
        walls_d = cell_rdata_q.walls &
                  ((first_q || popped_q) ? WallAll : ~back_wall(last_dir_q));
        if (!cell_rdata_q.visited) begin
          seen_d = seen_q + cnt_t'(1);
        end
        first_d    = 1'b0;
        sum_lo_d   = digit_sum8(rnd_q[15:0]);
        sum_hi_d   = digit_sum8(rnd_q[31:16]);
        cell_re    = 1'b1;
        cell_raddr = cell_addr(step_pos(nbr_dir, walk_q, rows_used, cols_used));
        dir_d      = 2'd0;
        cand_d     = '0;
        state_d    = S_NBR;
      end

      // one neighbor visited bit per cycle
      S_NBR: begin
        cand_d[dir_q] = nbr_exists(dir_e'(dir_q), walk_q, rows_used, cols_used) &&
                        !cell_rdata_q.visited;
        if (dir_q == 2'd3) begin
          state_d = S_DECIDE;
        end else begin
          cell_re    = 1'b1;
          cell_raddr = cell_addr(step_pos(nbr_dir, walk_q, rows_used, cols_used));
          dir_d      = dir_q + 2'd1;
        end
      end

      // write back the cell, and push and move, or pop if the stack is not empty
      S_DECIDE: begin
        popped_d   = 1'b0;
        cell_we    = 1'b1;
        cell_waddr = cell_addr(walk_q);
        if (cand_q != '0) begin
          cell_wdata = '{visited: 1'b1, walls: walls_q & ~move_wall(pick)};
          if (32'(depth_q) < Cells) begin
            stack_we = 1'b1;
            depth_d  = depth_q + cnt_t'(1);
          end
          walk_d     = step_pos(pick, walk_q, rows_used, cols_used);
          last_dir_d = pick;
          moved_d    = 1'b1;
          state_d    = S_FINCHK;
        end else begin
          cell_wdata = '{visited: 1'b1, walls: walls_q};
          popped_d   = 1'b1;
          if (depth_q != '0) begin
            stack_re = 1'b1;
            depth_d  = depth_m1;
            state_d  = S_POP;
          end else begin
            state_d = S_FINCHK;
          end
        end
      end

      S_POP: begin
        walk_d  = stack_rdata_q;
        state_d = S_FINCHK;
      end

      // on completion open entrance and exit before the report, else report
      S_FINCHK: begin
        cell_re = 1'b1;
        if (finished) begin
          cell_raddr = cell_addr(entry_pos);
          state_d    = S_ENT_WR;
        end else begin
          cell_raddr = cell_addr(walk_q);
          state_d    = S_REPORT;
        end
      end

      S_ENT_WR: begin
        cell_we    = 1'b1;
        cell_waddr = cell_addr(entry_pos);
        cell_wdata = '{visited: cell_rdata_q.visited,
                       walls: cell_rdata_q.walls & ~WallLeft};
        state_d    = S_EXIT_RD;
      end

      S_EXIT_RD: begin
        cell_re    = 1'b1;
        cell_raddr = cell_addr(exit_pos);
        state_d    = S_EXIT_WR;
      end

      S_EXIT_WR: begin
        cell_we    = 1'b1;
        cell_waddr = cell_addr(exit_pos);
        cell_wdata = '{visited: cell_rdata_q.visited,
                       walls: cell_rdata_q.walls & ~WallRight};
        state_d    = S_REP_RD;
      end

      S_REP_RD: begin
        cell_re    = 1'b1;
        cell_raddr = cell_addr(walk_q);
        state_d    = S_REPORT;
      end

      // load the output register once it is free
      S_REPORT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_row_d   = walk_q.row[PosW-1:0];
          out_col_d   = walk_q.col[PosW-1:0];
          out_walls_d = cell_rdata_q.walls;
          out_fin_d   = finished;
          out_adv_d   = moved_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q  <= coord_t'(MaxRowsDef);
      cols_cfg_q  <= coord_t'(MaxColsDef);
      start_row_q <= '0;
      start_col_q <= '0;
      entry_row_q <= '0;
      exit_row_q  <= '0;
      state_q     <= S_CLEAR;
      walk_q      <= '0;
      seen_q      <= '0;
      depth_q     <= '0;
      first_q     <= 1'b1;
      popped_q    <= 1'b0;
      last_dir_q  <= DIR_DOWN;
      moved_q     <= 1'b0;
      dir_q       <= '0;
      cand_q      <= '0;
      clr_q       <= '0;
      clr_rep_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rows_cfg_q  <= rows_cfg_d;
      cols_cfg_q  <= cols_cfg_d;
      start_row_q <= start_row_d;
      start_col_q <= start_col_d;
      entry_row_q <= entry_row_d;
      exit_row_q  <= exit_row_d;
      state_q     <= state_d;
      walk_q      <= walk_d;
      seen_q      <= seen_d;
      depth_q     <= depth_d;
      first_q     <= first_d;
      popped_q    <= popped_d;
      last_dir_q  <= last_dir_d;
      moved_q     <= moved_d;
      dir_q       <= dir_d;
      cand_q      <= cand_d;
      clr_q       <= clr_d;
      clr_rep_q   <= clr_rep_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    walls_q     <= walls_d;
    rnd_q       <= rnd_d;
    sum_lo_q    <= sum_lo_d;
    sum_hi_q    <= sum_hi_d;
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
    out_walls_q <= out_walls_d;
    out_fin_q   <= out_fin_d;
    out_adv_q   <= out_adv_d;
  end

  // cell memory
  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (cell_re) begin
      cell_rdata_q <= cell_mem[cell_raddr];
    end
  end

  // backtrack stack memory
  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    if (stack_re) begin
      stack_rdata_q <= stack_mem[stack_raddr];
    end
  end

  // channel outputs
  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.pos_row   = out_row_q;
  assign out_o.pos_col   = out_col_q;
  assign out_o.wall_bits = out_walls_q;
  assign out_o.finished  = out_fin_q;
  assign out_o.advanced  = out_adv_q;

endmodule

// File: hdl/gmb_checker.sv
`include "grid_maze_backtracker_unit_macros.svh"

module gmb_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [gmb_pkg::PosW-1:0]  out_row_i,
  input logic [gmb_pkg::PosW-1:0]  out_col_i,
  input logic [gmb_pkg::WallW-1:0] out_walls_i,
  input logic                      out_fin_i,
  input logic                      out_adv_i
);
  import gmb_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] pending_q, pending_d;

  // requests taken whose result has not yet been handed over
  assign in_acc    = in_valid_i && in_ready_i;
  assign out_acc   = out_valid_i && out_ready_i;
  assign pending_d = pending_q + 2'(in_acc) - 2'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // a stalled result stays offered
  `GMB_ASSERT_NXT(a_out_valid_hold, out_valid_i && !out_ready_i, out_valid_i, "result withdrawn while stalled")

  // a stalled result keeps its fields
  `GMB_ASSERT_NXT(a_out_data_hold, out_valid_i && !out_ready_i, $stable(out_row_i) && $stable(out_col_i) && $stable(out_walls_i) && $stable(out_fin_i) && $stable(out_adv_i), "result changed while stalled")

  // no result without a request behind it
  `GMB_ASSERT_IMP(a_no_phantom, out_valid_i, pending_q != 2'd0, "result with no request pending")

endmodule

bind grid_maze_backtracker_unit gmb_checker u_gmb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_row_i   (out_o.pos_row),
  .out_col_i   (out_o.pos_col),
  .out_walls_i (out_o.wall_bits),
  .out_fin_i   (out_o.finished),
  .out_adv_i   (out_o.advanced)
);
